[sv/ellipsoid_vertex_projection_macros.svh]
// Assertion macros used by the projection pipeline top level.
`ifndef ELLIPSOID_VERTEX_PROJECTION_MACROS_SVH
`define ELLIPSOID_VERTEX_PROJECTION_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define EVP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the clock edge after the antecedent.
`define EVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/evp_pkg.sv]
// Package: shared constants and types of the ellipsoid vertex projection block.
`timescale 1ns / 1ps
package evp_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS_X = 3'd3,
        REG_RADIUS_Y = 3'd4,
        REG_RADIUS_Z = 3'd5
    } reg_idx_t;

    // Pipeline advance control handed to every stage.
    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;
endpackage

[sv/evp_isqrt_stage.sv]
// One restoring square-root step plus a delay line for the side payload.
`timescale 1ns / 1ps
module evp_isqrt_stage #(
    parameter int SW = 64,
    parameter int PW = 8,
    parameter int BITPOS = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  evp_pkg::pipe_ctrl_t ctrl,
    input  logic              vin,
    input  logic [SW-1:0]     rem_in,
    input  logic [SW/2-1:0]   root_in,
    input  logic [PW-1:0]     pay_in,
    output logic              vout,
    output logic [SW-1:0]     rem_out,
    output logic [SW/2-1:0]   root_out,
    output logic [PW-1:0]     pay_out
);
    logic [SW+1:0] trial;
    logic [SW-1:0] rem_next;
    logic [SW/2-1:0] root_next;
    logic          vld_reg;
    logic [SW-1:0] rem_reg;
    logic [SW/2-1:0] root_reg;
    logic [PW-1:0] pay_reg;

    // Trial subtract of (2*root+1) << 2*BITPOS, where root holds the upper bits.
    always_comb
    begin
        trial = {2'b00, rem_in}
            - (({{(SW/2+2){1'b0}}, root_in} << (BITPOS + 1))
               + ({{(SW+1){1'b0}}, 1'b1} << (2 * BITPOS)));
        if (!trial[SW+1])
        begin
            rem_next  = trial[SW-1:0];
            root_next = root_in | (SW/2)'(1) << BITPOS;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctrl.advance)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pay_reg  <= pay_in;
        end
    end

    assign vout     = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign pay_out  = pay_reg;
endmodule

[sv/evp_div_stage.sv]
// One restoring division step for the three normal components at once.
`timescale 1ns / 1ps
module evp_div_stage #(
    parameter int QW = 18,
    parameter int DW = 32,
    parameter int PW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  evp_pkg::pipe_ctrl_t ctrl,
    input  logic              vin,
    input  logic [3*DW-1:0]   rem_in,
    input  logic [3*QW-1:0]   quo_in,
    input  logic [DW-1:0]     den,
    input  logic [3*DW-1:0]   numbit,
    input  logic [PW-1:0]     pay_in,
    output logic              vout,
    output logic [3*DW-1:0]   rem_out,
    output logic [3*QW-1:0]   quo_out,
    output logic [PW-1:0]     pay_out
);
    logic [3*DW-1:0] rem_next;
    logic [3*QW-1:0] quo_next;
    logic [DW:0]     sh [3];
    logic [DW:0]     df [3];
    logic            vld_reg;
    logic [3*DW-1:0] rem_reg;
    logic [3*QW-1:0] quo_reg;
    logic [PW-1:0]   pay_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sh[k] = {rem_in[k*DW +: DW], numbit[k*DW]};
            df[k] = sh[k] - {1'b0, den};
            if (!df[k][DW])
            begin
                rem_next[k*DW +: DW] = df[k][DW-1:0];
                quo_next[k*QW +: QW] = {quo_in[k*QW +: QW-1], 1'b1};
            end
            else
            begin
                rem_next[k*DW +: DW] = sh[k][DW-1:0];
                quo_next[k*QW +: QW] = {quo_in[k*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctrl.advance)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            pay_reg <= pay_in;
        end
    end

    assign vout    = vld_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign pay_out = pay_reg;
endmodule

[sv/ellipsoid_vertex_projection.sv]
// Top level: streaming ellipsoid vertex projection pipeline with APB registers.
//
//  Channel | Direction | Transaction content
//  --------+-----------+-------------------------------------------------
//  s_axis  | in        | start/end positions and blend factor, one pair
//  m_axis  | out       | projected position, normal, degenerate flag
//  apb     | in/out    | center_x/y/z, radius_x/y/z at byte 4*index
//
// One vertex pair enters every cycle unless m_axis stalls; the depth is set by
// the one-bit-per-stage square-root and divider chains.
// rst_n clears all valid bits and loads the register reset values.
// A stall on m_axis freezes every stage together; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "ellipsoid_vertex_projection_macros.svh"
module ellipsoid_vertex_projection #(
    parameter int COORD_WIDTH = evp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = evp_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z, blend (lowest first)
    input  logic [((6*COORD_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // out_x, out_y, out_z, normal_x, normal_y, normal_z (lowest first)
    output logic [((3*COORD_WIDTH+3*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0] m_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int C   = COORD_WIDTH;
    localparam int Q   = FRAC_BITS;
    localparam int NW  = Q + 2;
    localparam int IW  = ((6*C+Q+1+7)/8)*8;
    localparam int OW  = ((3*C+3*NW+7)/8)*8;
    localparam int UW  = 30;              // normalized magnitude width
    localparam int SW  = 64;              // sum of squares width
    localparam int LW  = SW / 2;          // root width
    localparam int DW  = LW + 1;          // divider remainder width
    localparam int DIVN = UW + Q;         // dividend width
    localparam int SHW = 7;               // shift amount width
    localparam int PAYW = 3*C + 3 + 3*UW + 1;
    localparam int DPW  = 3*C + 3 + 1;

    // Configuration registers.
    logic signed [C-1:0] center_reg [3];
    logic        [C-2:0] radius_reg [3];
    logic                wr_en;
    logic [2:0]          widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                center_reg[k] <= '0;
                radius_reg[k] <= (C-1)'(1) << Q;
            end
        end
        else if (wr_en)
        begin
            unique case (widx)
                evp_pkg::REG_CENTER_X: center_reg[0] <= C'(pwdata);
                evp_pkg::REG_CENTER_Y: center_reg[1] <= C'(pwdata);
                evp_pkg::REG_CENTER_Z: center_reg[2] <= C'(pwdata);
                evp_pkg::REG_RADIUS_X: radius_reg[0] <= (C-1)'(pwdata);
                evp_pkg::REG_RADIUS_Y: radius_reg[1] <= (C-1)'(pwdata);
                evp_pkg::REG_RADIUS_Z: radius_reg[2] <= (C-1)'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            evp_pkg::REG_CENTER_X: prdata = 32'(center_reg[0]);
            evp_pkg::REG_CENTER_Y: prdata = 32'(center_reg[1]);
            evp_pkg::REG_CENTER_Z: prdata = 32'(center_reg[2]);
            evp_pkg::REG_RADIUS_X: prdata = 32'(radius_reg[0]);
            evp_pkg::REG_RADIUS_Y: prdata = 32'(radius_reg[1]);
            evp_pkg::REG_RADIUS_Z: prdata = 32'(radius_reg[2]);
            default:               prdata = '0;
        endcase
    end

    // Global stall: every stage advances when the output slot is free.
    evp_pkg::pipe_ctrl_t ctrl;
    logic out_vld_reg;
    assign ctrl.advance   = !out_vld_reg || m_axis_tready;
    assign s_axis_tready  = ctrl.advance;
    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Stage 1: blend products hi*t and lo*t.
    logic [Q:0] t_clamp;
    assign t_clamp = (s_axis_tdata[6*C +: Q+1] > (Q+1)'(1) << Q)
        ? (Q+1)'(1) << Q : s_axis_tdata[6*C +: Q+1];

    logic                   s1_v_reg;
    logic signed [C-1:0]    s1_a_reg [3];
    logic signed [C+Q+1:0]  s1_hit_reg [3];
    logic signed [2*Q+1:0]  s1_lot_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (ctrl.advance)
            s1_v_reg <= in_fire;
    end
    always_ff @(posedge clk)
    begin
        logic signed [C:0] df;
        if (ctrl.advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                df = (C+1)'($signed(s_axis_tdata[(3+k)*C +: C]))
                   - (C+1)'($signed(s_axis_tdata[k*C +: C]));
                s1_a_reg[k]   <= $signed(s_axis_tdata[k*C +: C]);
                s1_hit_reg[k] <= (C+Q+2)'(df >>> Q) * $signed({1'b0, t_clamp});
                s1_lot_reg[k] <= $signed({1'b0, df[Q-1:0]}) * $signed({1'b0, t_clamp});
            end
        end
    end

    // Stage 2: blended point minus center, magnitude and sign.
    logic             s2_v_reg;
    logic [C:0]       s2_u_reg [3];
    logic [2:0]       s2_neg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (ctrl.advance)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [C+1:0] d;
        if (ctrl.advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d = (C+2)'(s1_a_reg[k]) + (C+2)'(s1_hit_reg[k])
                  + (C+2)'(s1_lot_reg[k] >>> Q) - (C+2)'(center_reg[k]);
                s2_neg_reg[k] <= d[C+1];
                s2_u_reg[k]   <= d[C+1] ? (C+1)'(-d) : (C+1)'(d);
            end
        end
    end

    // Stage 3: leading-one position of the max magnitude.
    logic             s3_v_reg;
    logic [C:0]       s3_u_reg [3];
    logic [2:0]       s3_neg_reg;
    logic [SHW-1:0]   s3_msb_reg;
    logic             s3_zero_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (ctrl.advance)
            s3_v_reg <= s2_v_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [C:0] orv;
        logic [SHW-1:0] pos;
        if (ctrl.advance)
        begin
            orv = s2_u_reg[0] | s2_u_reg[1] | s2_u_reg[2];
            pos = '0;
            for (int b = 0; b <= C; b++)
                if (orv[b])
                    pos = SHW'(b);
            s3_u_reg    <= s2_u_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_msb_reg  <= pos;
            s3_zero_reg <= (orv == '0);
        end
    end

    // Stage 4: shift magnitudes so the max lands in [2^29, 2^30).
    logic             s4_v_reg;
    logic [UW-1:0]    s4_u_reg [3];
    logic [2:0]       s4_neg_reg;
    logic             s4_zero_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (ctrl.advance)
            s4_v_reg <= s3_v_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [C+UW:0] w;
        if (ctrl.advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w = (C+UW+1)'(s3_u_reg[k]);
                if (s3_msb_reg >= SHW'(UW-1))
                    s4_u_reg[k] <= UW'(w >> (s3_msb_reg - SHW'(UW-1)));
                else
                    s4_u_reg[k] <= UW'(w << (SHW'(UW-1) - s3_msb_reg));
            end
            s4_neg_reg  <= s3_neg_reg;
            s4_zero_reg <= s3_zero_reg;
        end
    end

    // Stage 5: squares (30x30 each).
    logic             s5_v_reg;
    logic [2*UW-1:0]  s5_sq_reg [3];
    logic [PAYW-1:0]  s5_pay_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (ctrl.advance)
            s5_v_reg <= s4_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int k = 0; k < 3; k++)
                s5_sq_reg[k] <= s4_u_reg[k] * s4_u_reg[k];
            s5_pay_reg <= {center_reg[2], center_reg[1], center_reg[0], s4_neg_reg,
                           s4_u_reg[2], s4_u_reg[1], s4_u_reg[0], s4_zero_reg};
        end
    end

    // Stage 6: sum of squares.
    logic             s6_v_reg;
    logic [SW-1:0]    s6_sum_reg;
    logic [PAYW-1:0]  s6_pay_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_v_reg <= 1'b0;
        else if (ctrl.advance)
            s6_v_reg <= s5_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s6_sum_reg <= SW'(s5_sq_reg[0]) + SW'(s5_sq_reg[1]) + SW'(s5_sq_reg[2]);
            s6_pay_reg <= s5_pay_reg;
        end
    end

    // Square root: one result bit per stage, most significant first.
    logic              sq_v   [LW+1];
    logic [SW-1:0]     sq_rem [LW+1];
    logic [LW-1:0]     sq_rt  [LW+1];
    logic [PAYW-1:0]   sq_pay [LW+1];
    assign sq_v[0]   = s6_v_reg;
    assign sq_rem[0] = s6_sum_reg;
    assign sq_rt[0]  = '0;
    assign sq_pay[0] = s6_pay_reg;
    for (genvar g = 0; g < LW; g++)
    begin : g_sqrt
        evp_isqrt_stage #(.SW(SW), .PW(PAYW), .BITPOS(LW-1-g)) u_stage (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
            .vin(sq_v[g]), .rem_in(sq_rem[g]), .root_in(sq_rt[g]), .pay_in(sq_pay[g]),
            .vout(sq_v[g+1]), .rem_out(sq_rem[g+1]), .root_out(sq_rt[g+1]),
            .pay_out(sq_pay[g+1])
        );
    end

    // Stage 7: prepare divider, numerator u*2^Q + L/2 and denominator L.
    logic             s7_v_reg;
    logic [DIVN:0]    s7_num_reg [3];
    logic [DW-1:0]    s7_den_reg;
    logic [DPW-1:0]   s7_pay_reg;
    logic [UW-1:0]    sq_u [3];
    assign sq_u[0] = sq_pay[LW][1 +: UW];
    assign sq_u[1] = sq_pay[LW][1+UW +: UW];
    assign sq_u[2] = sq_pay[LW][1+2*UW +: UW];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_v_reg <= 1'b0;
        else if (ctrl.advance)
            s7_v_reg <= sq_v[LW];
    end
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int k = 0; k < 3; k++)
                s7_num_reg[k] <= (DIVN+1)'({sq_u[k], {Q{1'b0}}})
                               + (DIVN+1)'(sq_rt[LW] >> 1);
            s7_den_reg <= DW'(sq_rt[LW]);
            s7_pay_reg <= {sq_pay[LW][PAYW-1 -: 3*C+3], sq_pay[LW][0]};
        end
    end

    // Division: quotient needs only NW bits since it never exceeds 2^Q.
    // Leading bits above NW are known zero, so preload them into the remainder.
    logic              dv_v   [NW+1];
    logic [3*DW-1:0]   dv_rem [NW+1];
    logic [3*NW-1:0]   dv_quo [NW+1];
    logic [DPW-1:0]    dv_pay [NW+1];
    logic [DW-1:0]     dv_den [NW+1];
    logic [DIVN:0]     dv_num [NW+1][3];
    assign dv_v[0]   = s7_v_reg;
    assign dv_quo[0] = '0;
    assign dv_pay[0] = s7_pay_reg;
    assign dv_den[0] = s7_den_reg;
    for (genvar k = 0; k < 3; k++)
    begin : g_pre
        assign dv_rem[0][k*DW +: DW] = DW'(s7_num_reg[k] >> NW);
        assign dv_num[0][k] = s7_num_reg[k];
    end
    for (genvar g = 0; g < NW; g++)
    begin : g_div
        logic [3*DW-1:0] nb;
        logic [DW-1:0]   den_reg;
        logic [DIVN:0]   num_reg [3];
        for (genvar k = 0; k < 3; k++)
        begin : g_nb
            assign nb[k*DW +: DW] = DW'(dv_num[g][k][NW-1-g]);
            assign dv_num[g+1][k] = num_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                den_reg <= dv_den[g];
                for (int k = 0; k < 3; k++)
                    num_reg[k] <= dv_num[g][k];
            end
        end
        assign dv_den[g+1] = den_reg;
        evp_div_stage #(.QW(NW), .DW(DW), .PW(DPW)) u_stage (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
            .vin(dv_v[g]), .rem_in(dv_rem[g]), .quo_in(dv_quo[g]),
            .den(dv_den[g]), .numbit(nb), .pay_in(dv_pay[g]),
            .vout(dv_v[g+1]), .rem_out(dv_rem[g+1]), .quo_out(dv_quo[g+1]),
            .pay_out(dv_pay[g+1])
        );
    end

    // Stage 8: signed normals and radius products.
    logic                 dz;
    logic [2:0]           dneg;
    logic signed [C-1:0]  dctr [3];
    assign dz   = dv_pay[NW][0];
    assign dneg = dv_pay[NW][1 +: 3];
    for (genvar k = 0; k < 3; k++)
    begin : g_dctr
        assign dctr[k] = $signed(dv_pay[NW][4+k*C +: C]);
    end

    logic                 s8_v_reg;
    logic signed [NW-1:0] s8_n_reg [3];
    logic signed [NW+C-1:0] s8_p_reg [3];
    logic signed [C-1:0]  s8_c_reg [3];
    logic                 s8_z_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_v_reg <= 1'b0;
        else if (ctrl.advance)
            s8_v_reg <= dv_v[NW];
    end
    always_ff @(posedge clk)
    begin
        logic signed [NW-1:0] n;
        if (ctrl.advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n = dz ? '0 : (dneg[k] ? -$signed(dv_quo[NW][k*NW +: NW])
                                       : $signed(dv_quo[NW][k*NW +: NW]));
                s8_n_reg[k] <= n;
                s8_p_reg[k] <= (NW+C)'(n) * $signed({1'b0, radius_reg[k]});
                s8_c_reg[k] <= dctr[k];
            end
            s8_z_reg <= dz;
        end
    end

    // Output register: round, add center, saturate.
    logic [OW-1:0] out_data_reg;
    logic          out_deg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (ctrl.advance)
            out_vld_reg <= s8_v_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [NW+C:0] sc;
        logic signed [NW+C+1:0] o;
        logic [OW-1:0] od;
        if (ctrl.advance)
        begin
            od = '0;
            for (int k = 0; k < 3; k++)
            begin
                sc = ((NW+C+1)'(s8_p_reg[k]) + (NW+C+1)'(1 << (Q-1))) >>> Q;
                o  = (NW+C+2)'(sc) + (NW+C+2)'(s8_c_reg[k]);
                if (o > $signed((NW+C+2)'({1'b0, {(C-1){1'b1}}})))
                    od[k*C +: C] = {1'b0, {(C-1){1'b1}}};
                else if (o < -$signed((NW+C+2)'({1'b1, {(C-1){1'b0}}})))
                    od[k*C +: C] = {1'b1, {(C-1){1'b0}}};
                else
                    od[k*C +: C] = o[C-1:0];
                od[3*C+k*NW +: NW] = s8_n_reg[k];
            end
            out_data_reg <= od;
            out_deg_reg  <= s8_z_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_deg_reg;

    `EVP_ASSERT_NEXT(a_hold_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `EVP_ASSERT_IMPL(a_ready_free, clk, rst_n, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
    `EVP_ASSERT_IMPL(a_deg_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[3*C +: 3*NW] == '0, "degenerate result with nonzero normal")
endmodule
